>>> design/toc_pkg.sv
// Shared types, widths, register codes and clamp helpers of the tile occupancy reducer.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package toc_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int DIM_W       = 11;
    localparam int TILE_W      = 9;
    localparam int OFF_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int STORE_DEPTH = 1024;
    localparam int TC_W        = $clog2(STORE_DEPTH);
    localparam int FIFO_DEPTH  = 3;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 2;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int FIELD_LIMIT = 1024;
    localparam int WIDTH_LIMIT  = (MAX_WIDTH < FIELD_LIMIT) ? MAX_WIDTH : FIELD_LIMIT;
    localparam int HEIGHT_LIMIT = (MAX_HEIGHT < FIELD_LIMIT) ? MAX_HEIGHT : FIELD_LIMIT;
    localparam int TILE_LIMIT  = 256;

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(480);
    localparam logic [TILE_W-1:0] TILE_RESET   = TILE_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_TILE_SIZE    = 2'd2
    } toc_reg_t;

    // One accepted pixel, as it leaves the position counters
    typedef struct packed {
        logic [TC_W-1:0]    tc;
        logic               first;
        logic               black;
        logic               emit;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic               last;
    } toc_step_t;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic               occupied;
        logic               last_tile;
    } toc_result_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        return r;
    endfunction

    function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        r = v;
        if (v == '0)
            r = TILE_W'(1);
        else if (v > TILE_W'(TILE_LIMIT))
            r = TILE_W'(TILE_LIMIT);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/toc_if.sv
// Valid/ready channel interfaces: pixel input and tile result output.
// Depends on toc_pkg for field widths.
`default_nettype none

interface toc_pix_if;
    logic                      valid;
    logic                      ready;
    logic [toc_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface toc_tile_if;
    logic                        valid;
    logic                        ready;
    logic [toc_pkg::COORD_W-1:0] tile_origin_x;
    logic [toc_pkg::COORD_W-1:0] tile_origin_y;
    logic                        occupied;
    logic                        last_tile;

    modport source (output valid, output tile_origin_x, output tile_origin_y,
                    output occupied, output last_tile, input ready);
    modport sink   (input valid, input tile_origin_x, input tile_origin_y,
                    input occupied, input last_tile, output ready);
endinterface

`default_nettype wire

>>> design/tile_occupancy_reducer_core.sv
// Channel  Dir  Payload                                        Transaction
// pixel    in   pixel_value[7:0]                               valid & ready
// tile     out  tile_origin_x/y[9:0], occupied, last_tile      valid & ready
// cfg      in   cfg_index[1:0], cfg_data[10:0]                 cfg_we
//
// One pixel per cycle. A pixel's flag read issues on acceptance, the tile column flag
// is merged and written back in the cycle after, and a same-column write in flight is
// forwarded. A result enters the output queue in the cycle after its closing pixel is taken.
// Input stalls while the three-entry output queue is full, or holds two while one is pushed.
// Reset restores the register defaults and the frame origin; the flag store is not cleared.
// Depends on toc_pkg, toc_if, toc_pos, toc_flag_ram and toc_out_fifo.
`default_nettype none

module tile_occupancy_reducer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [toc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [toc_pkg::DIM_W-1:0]     cfg_data,
    toc_pix_if.sink                            pixel,
    toc_tile_if.source                         tile
);
    import toc_pkg::*;

    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [TILE_W-1:0] tile_reg, tile_next;

    toc_step_t step;
    toc_step_t s1_reg;
    logic      s1_valid_reg;
    logic      fwd_reg;
    logic      fwd_flag_reg;

    logic                  accept;
    logic                  in_ready;
    logic                  rd_data;
    logic                  old_flag;
    logic                  new_flag;
    logic                  push;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] fifo_count;
    toc_result_t           result;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        tile_next   = tile_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                REG_TILE_SIZE:    tile_next   = cfg_data[TILE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            tile_reg   <= TILE_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            tile_reg   <= tile_next;
        end
    end

    // Leave room for the result in stage one and one more
    assign in_ready    = (fifo_count < FIFO_CNT_W'(2)) ||
                         (fifo_count == FIFO_CNT_W'(2) && !push);
    assign pixel.ready = in_ready;
    assign accept      = pixel.valid && in_ready;

    toc_pos u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_we),
        .advance     (accept),
        .pixel_value (pixel.pixel_value),
        .width       (clamp_dim(width_reg, DIM_W'(WIDTH_LIMIT))),
        .height      (clamp_dim(height_reg, DIM_W'(HEIGHT_LIMIT))),
        .tile        (clamp_tile(tile_reg)),
        .step        (step)
    );

    toc_flag_ram u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (step.tc),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_reg.tc),
        .wr_data (new_flag)
    );

    always_comb
    begin
        old_flag        = fwd_reg ? fwd_flag_reg : rd_data;
        new_flag        = s1_reg.first ? s1_reg.black : (old_flag || s1_reg.black);
        push            = s1_valid_reg && s1_reg.emit;
        result.origin_x = s1_reg.origin_x;
        result.origin_y = s1_reg.origin_y;
        result.occupied = new_flag;
        result.last_tile = s1_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= step;
            fwd_flag_reg <= new_flag;
        end
    end

    // Forward the flag being written when the next pixel reads the same column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
                fwd_reg <= s1_valid_reg && (s1_reg.tc == step.tc);
        end
    end

    toc_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .count     (fifo_count),
        .pop       (pop),
        .tile      (tile)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (fifo_count != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_fwd_same_column: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg && s1_reg.tc == step.tc) |=> fwd_reg)
        else $error("missing flag forward on same tile column");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel lost before flag merge");

endmodule

`default_nettype wire

>>> design/toc_pos.sv
// Raster position counters: pixel, in-tile offset and tile column of the next pixel.
// Depends on toc_pkg; produces the per-pixel step record for the flag pipeline.
`default_nettype none

module toc_pos (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        restart,
    input  wire logic                        advance,
    input  wire logic [toc_pkg::PIX_W-1:0]   pixel_value,
    input  wire logic [toc_pkg::DIM_W-1:0]   width,
    input  wire logic [toc_pkg::DIM_W-1:0]   height,
    input  wire logic [toc_pkg::TILE_W-1:0]  tile,
    output toc_pkg::toc_step_t               step
);
    import toc_pkg::*;

    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [OFF_W-1:0]   ox_reg, ox_next;
    logic [OFF_W-1:0]   oy_reg, oy_next;
    logic [TC_W-1:0]    tc_reg, tc_next;

    logic [DIM_W-1:0]  x_inc, y_inc;
    logic [TILE_W-1:0] ox_inc, oy_inc;
    logic row_end, col_end, tx_end, ty_end;

    always_comb
    begin
        x_inc   = {1'b0, x_reg} + DIM_W'(1);
        y_inc   = {1'b0, y_reg} + DIM_W'(1);
        ox_inc  = {1'b0, ox_reg} + TILE_W'(1);
        oy_inc  = {1'b0, oy_reg} + TILE_W'(1);
        row_end = x_inc >= width;
        col_end = y_inc >= height;
        tx_end  = ox_inc >= tile;
        ty_end  = oy_inc >= tile;

        step.tc       = tc_reg;
        step.first    = (ox_reg == '0) && (oy_reg == '0);
        step.black    = pixel_value == '0;
        step.emit     = (tx_end || row_end) && (ty_end || col_end);
        step.origin_x = x_reg - {{(COORD_W-OFF_W){1'b0}}, ox_reg};
        step.origin_y = y_reg - {{(COORD_W-OFF_W){1'b0}}, oy_reg};
        step.last     = row_end && col_end;
    end

    always_comb
    begin
        x_next  = x_reg;
        y_next  = y_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        tc_next = tc_reg;
        if (restart)
        begin
            x_next  = '0;
            y_next  = '0;
            ox_next = '0;
            oy_next = '0;
            tc_next = '0;
        end
        else if (advance)
        begin
            if (row_end)
            begin
                x_next  = '0;
                ox_next = '0;
                tc_next = '0;
                if (col_end)
                begin
                    y_next  = '0;
                    oy_next = '0;
                end
                else
                begin
                    y_next  = y_inc[COORD_W-1:0];
                    oy_next = ty_end ? '0 : oy_inc[OFF_W-1:0];
                end
            end
            else
            begin
                x_next = x_inc[COORD_W-1:0];
                if (tx_end)
                begin
                    ox_next = '0;
                    tc_next = tc_reg + TC_W'(1);
                end
                else
                begin
                    ox_next = ox_inc[OFF_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            tc_reg <= '0;
        end
        else
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            tc_reg <= tc_next;
        end
    end

endmodule

`default_nettype wire

>>> design/toc_flag_ram.sv
// Per tile column occupancy flag store: one write and one registered read port.
// Depends on toc_pkg for depth and address width.
`default_nettype none

module toc_flag_ram (
    input  wire logic                      clk,
    input  wire logic                      rd_en,
    input  wire logic [toc_pkg::TC_W-1:0]  rd_addr,
    output logic                           rd_data,
    input  wire logic                      wr_en,
    input  wire logic [toc_pkg::TC_W-1:0]  wr_addr,
    input  wire logic                      wr_data
);
    import toc_pkg::*;

    logic mem [STORE_DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read returns the old contents on a same-address write; the caller forwards
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/toc_out_fifo.sv
// Three-entry result queue that drives the tile output channel.
// Depends on toc_pkg and the toc_tile_if interface.
`default_nettype none

module toc_out_fifo (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  toc_pkg::toc_result_t                   push_data,
    output logic [toc_pkg::FIFO_CNT_W-1:0]         count,
    output logic                                   pop,
    toc_tile_if.source                             tile
);
    import toc_pkg::*;

    toc_result_t           mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    toc_result_t           head;

    function automatic logic [FIFO_PTR_W-1:0] wrap_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
    endfunction

    assign pop  = tile.valid && tile.ready;
    assign head = mem[rd_ptr_reg];

    always_comb
    begin
        tile.valid         = cnt_reg != '0;
        tile.tile_origin_x = head.origin_x;
        tile.tile_origin_y = head.origin_y;
        tile.occupied      = head.occupied;
        tile.last_tile     = head.last_tile;
        count              = cnt_reg;
    end

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> verif/toc_tile_checker.sv
// Tile result checker: follows the pixel raster, predicts every tile result and
// compares it with what the block hands out. Depends on toc_pkg and toc_if.
`default_nettype none

module toc_tile_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [toc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [toc_pkg::DIM_W-1:0]     cfg_data,
    toc_pix_if                            pix,
    toc_tile_if                           tile,
    output int                            mismatches,
    output int                            outstanding,
    output int                            tiles_checked,
    output int                            occupied_tiles,
    output int                            frames_closed
);
    import toc_pkg::*;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [TILE_W-1:0]  tile_reg;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    logic [OFF_W-1:0]   off_x;
    logic [OFF_W-1:0]   off_y;
    logic [TC_W-1:0]    tile_col;
    logic               occ_flags [STORE_DEPTH];
    toc_result_t        tile_queue [$];

    int fail_total    = 0;
    int checked_total = 0;
    int occ_total     = 0;
    int last_total    = 0;

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("[%0t] tile check: %s", $time, msg);
    endtask

    task automatic restart_raster();
        col_pos  = '0;
        row_pos  = '0;
        off_x    = '0;
        off_y    = '0;
        tile_col = '0;
    endtask

    task automatic predict_pixel(input logic [PIX_W-1:0] value);
        int          w;
        int          h;
        int          t;
        int          x;
        int          y;
        int          ox;
        int          oy;
        bit          black;
        bit          row_end;
        bit          col_end;
        toc_result_t r;

        // out-of-range settings fold into the legal range
        w = width_reg;
        if (width_reg == '0)
            w = 1;
        else if (width_reg > WIDTH_LIMIT)
            w = WIDTH_LIMIT;
        h = height_reg;
        if (height_reg == '0)
            h = 1;
        else if (height_reg > HEIGHT_LIMIT)
            h = HEIGHT_LIMIT;
        t = tile_reg;
        if (tile_reg == '0)
            t = 1;
        else if (tile_reg > TILE_LIMIT)
            t = TILE_LIMIT;

        x       = col_pos;
        y       = row_pos;
        ox      = off_x;
        oy      = off_y;
        black   = (value == '0);
        row_end = (x + 1 >= w);
        col_end = (y + 1 >= h);

        // first pixel of a tile starts its flag fresh
        if (ox == 0 && oy == 0)
            occ_flags[tile_col] = black;
        else if (black)
            occ_flags[tile_col] = 1'b1;

        if ((ox + 1 >= t || row_end) && (oy + 1 >= t || col_end))
        begin
            r.origin_x  = COORD_W'(x - ox);
            r.origin_y  = COORD_W'(y - oy);
            r.occupied  = occ_flags[tile_col];
            r.last_tile = row_end && col_end;
            tile_queue  = {tile_queue, r};
        end

        if (row_end)
        begin
            col_pos  = '0;
            off_x    = '0;
            tile_col = '0;
            if (col_end)
            begin
                row_pos = '0;
                off_y   = '0;
            end
            else
            begin
                row_pos = COORD_W'(y + 1);
                off_y   = (oy + 1 >= t) ? '0 : OFF_W'(oy + 1);
            end
        end
        else
        begin
            col_pos = COORD_W'(x + 1);
            if (ox + 1 >= t)
            begin
                off_x    = '0;
                tile_col = tile_col + 1'b1;
            end
            else
                off_x = OFF_W'(ox + 1);
        end
    endtask

    task automatic check_tile();
        toc_result_t want;

        if (tile_queue.size() == 0)
            report_mismatch($sformatf("unexpected tile at (%0d,%0d) occupied %0d last %0d",
                tile.tile_origin_x, tile.tile_origin_y, tile.occupied, tile.last_tile));
        else
        begin
            want = tile_queue.pop_front();
            checked_total++;
            if (tile.tile_origin_x !== want.origin_x)
                report_mismatch($sformatf("tile_origin_x got %0d expected %0d",
                    tile.tile_origin_x, want.origin_x));
            if (tile.tile_origin_y !== want.origin_y)
                report_mismatch($sformatf("tile_origin_y got %0d expected %0d",
                    tile.tile_origin_y, want.origin_y));
            if (tile.occupied !== want.occupied)
                report_mismatch($sformatf("occupied got %0d expected %0d at (%0d,%0d)",
                    tile.occupied, want.occupied, want.origin_x, want.origin_y));
            if (tile.last_tile !== want.last_tile)
                report_mismatch($sformatf("last_tile got %0d expected %0d at (%0d,%0d)",
                    tile.last_tile, want.last_tile, want.origin_x, want.origin_y));
            if (want.occupied)
                occ_total++;
            if (want.last_tile)
                last_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            tile_reg   = TILE_RESET;
            restart_raster();
            tile_queue.delete();
        end
        else
        begin
            // any register write, known index or not, restarts the frame
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    REG_TILE_SIZE:    tile_reg = cfg_data[TILE_W-1:0];
                    default:          ;
                endcase
                restart_raster();
            end
            if (pix.valid && pix.ready)
                predict_pixel(pix.pixel_value);
            if (tile.valid && tile.ready)
                check_tile();
        end
        mismatches     <= fail_total;
        outstanding    <= tile_queue.size();
        tiles_checked  <= checked_total;
        occupied_tiles <= occ_total;
        frames_closed  <= last_total;
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Top of the tile occupancy reducer testbench: clock, reset, register writes,
// pixel stimulus and result back-pressure; the verdict comes from toc_tile_checker.
// Depends on toc_pkg, toc_if, tile_occupancy_reducer_core and toc_tile_checker.
`default_nettype none

module tb_top;
    import toc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 340;
    localparam int PHASE_CAP     = 96;
    localparam int HOLD_CYCLES   = 120;
    localparam int DIRECTED_LEN  = 26;

    // index past the register list: no register changes, the frame restarts
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    toc_pix_if  pix_ch ();
    toc_tile_if tile_ch ();

    int mismatches;
    int outstanding;
    int tiles_checked;
    int occupied_tiles;
    int frames_closed;

    int cycle_count    = 0;
    int pixels_sent    = 0;
    int settings_used  = 0;
    int hold_requests  = 0;
    int directed_index = 0;
    bit no_idle        = 1'b0;

    logic [PIX_W-1:0] directed_pixels [0:DIRECTED_LEN-1] = '{
        8'h00, 8'hFF,
        8'h7F, 8'h00, 8'hFE,
        8'hFF, 8'h55, 8'h00, 8'hAA, 8'hFF, 8'h01, 8'h00, 8'h20,
        8'h00, 8'h10,
        8'h01, 8'h02, 8'h00,
        8'h80, 8'h40, 8'h08, 8'h04, 8'hFF, 8'hC3, 8'h3C, 8'h01
    };

    always #CLK_HALF clk = ~clk;

    tile_occupancy_reducer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix_ch),
        .tile      (tile_ch)
    );

    toc_tile_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pix            (pix_ch),
        .tile           (tile_ch),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .tiles_checked  (tiles_checked),
        .occupied_tiles (occupied_tiles),
        .frames_closed  (frames_closed)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    function automatic logic [PIX_W-1:0] grey_pixel(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct)
            return '0;
        return PIX_W'($urandom_range(1, 255));
    endfunction

    // result receiver: random stalls plus long hold-offs on request
    initial
    begin
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        tile_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                tile_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!no_idle && $urandom_range(0, 99) < 25)
            begin
                tile_ch.ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end
            else
                tile_ch.ready <= 1'b1;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = (!no_idle && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= value;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic send_directed(input int count);
        repeat (count)
        begin
            send_pixel(directed_pixels[directed_index]);
            directed_index++;
        end
    endtask

    // hold the pixel side until every predicted tile is out, then let the pipe empty
    task automatic wait_idle(input int extra);
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_tiling(input logic [DIM_W-1:0] w_val, input logic [DIM_W-1:0] h_val,
                                  input logic [DIM_W-1:0] t_val);
        write_reg(REG_IMAGE_WIDTH, w_val);
        write_reg(REG_IMAGE_HEIGHT, h_val);
        write_reg(REG_TILE_SIZE, t_val);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] w_val, input logic [DIM_W-1:0] h_val,
                             input logic [DIM_W-1:0] t_val, input int count, input int zero_pct,
                             input bit hold);
        int pause_at;
        int restart_at;
        wait_idle(SETTLE_CYCLES);
        program_tiling(w_val, h_val, t_val);
        // start the receiver hold-off only once pixels are about to flow
        if (hold)
            hold_requests++;
        pause_at   = ($urandom_range(0, 99) < 20) ? $urandom_range(0, count - 1) : -1;
        restart_at = ($urandom_range(0, 99) < 10) ? $urandom_range(0, count - 1) : -1;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                wait_idle(0);
            // break the frame off with a write to the spare index
            if (i == restart_at)
            begin
                wait_idle(SETTLE_CYCLES);
                write_reg(REG_SPARE, DIM_W'($urandom_range(0, 2047)));
                cfg_we <= 1'b0;
            end
            send_pixel(grey_pixel(zero_pct));
        end
    endtask

    initial
    begin
        int w;
        int h;
        int t;
        int r;
        int frame;
        int count;
        int zero_pct;
        int random_start;
        logic [DIM_W-1:0] w_val;
        logic [DIM_W-1:0] h_val;
        logic [DIM_W-1:0] t_val;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_IMAGE_WIDTH;
        cfg_data           <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry, then single-pixel tiles on the default width
        send_directed(2);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_TILE_SIZE, DIM_W'(1));
        cfg_we <= 1'b0;
        send_directed(3);
        // 3x2 image in 2x2 tiles: clipped right tile closes the frame, then wrap
        wait_idle(SETTLE_CYCLES);
        program_tiling(DIM_W'(3), DIM_W'(2), DIM_W'(2));
        send_directed(8);
        // zero registers fold to a 1x1 image of 1x1 tiles
        wait_idle(SETTLE_CYCLES);
        program_tiling('0, '0, '0);
        send_directed(2);
        // restart mid-tile: the black pixel before the restart must not stick
        wait_idle(SETTLE_CYCLES);
        program_tiling(DIM_W'(4), DIM_W'(2), DIM_W'(4));
        send_directed(3);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_SPARE, '0);
        cfg_we <= 1'b0;
        send_directed(8);

        // register extremes; the first runs against a long receiver hold-off
        run_phase(DIM_W'(2047), DIM_W'(1), DIM_W'(1), 200, 10, 1'b1);
        run_phase('0, DIM_W'(1024), DIM_W'(1), 40, 30, 1'b0);
        run_phase(DIM_W'(1024), DIM_W'(1), DIM_W'(11'h3FF), 260, 2, 1'b0);
        run_phase(DIM_W'(5), DIM_W'(1500), DIM_W'(512), 40, 5, 1'b0);

        random_start = pixels_sent;
        while (pixels_sent < random_start + RANDOM_PIXELS)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                w = $urandom_range(1, 16);
            else if (r < 90)
                w = $urandom_range(17, 48);
            else
                w = $urandom_range(49, 128);
            h = (w > 48) ? $urandom_range(1, 4) : $urandom_range(1, 12);
            r = $urandom_range(0, 99);
            if (r < 50)
                t = $urandom_range(1, 4);
            else if (r < 85)
                t = $urandom_range(5, 16);
            else if (r < 95)
                t = w + $urandom_range(1, 8);
            else
                t = TILE_LIMIT;
            if (t > TILE_LIMIT)
                t = TILE_LIMIT;

            w_val = DIM_W'(w);
            h_val = DIM_W'(h);
            t_val = DIM_W'(t);
            if (w == 1 && $urandom_range(0, 1) == 1)
                w_val = '0;
            if (h == 1 && $urandom_range(0, 1) == 1)
                h_val = '0;
            if (t == 1 && $urandom_range(0, 1) == 1)
                t_val = ($urandom_range(0, 1) == 1) ? DIM_W'(512) : '0;
            if (t == TILE_LIMIT && $urandom_range(0, 1) == 1)
                t_val = DIM_W'($urandom_range(257, 511));

            frame = w * h;
            if ($urandom_range(0, 99) < 25)
                count = $urandom_range(1, frame);
            else
                count = frame + $urandom_range(0, frame);
            if (count > PHASE_CAP)
                count = PHASE_CAP;

            case ($urandom_range(0, 4))
                0:       zero_pct = 0;
                1:       zero_pct = 2;
                2:       zero_pct = 15;
                3:       zero_pct = 50;
                default: zero_pct = 90;
            endcase

            no_idle = ($urandom_range(0, 99) < 20);
            run_phase(w_val, h_val, t_val, count, zero_pct, $urandom_range(0, 99) < 8);
        end

        no_idle = 1'b0;
        wait_idle(SETTLE_CYCLES);
        $display("covered %0d pixels over %0d register settings; %0d tiles checked", pixels_sent,
                 settings_used, tiles_checked);
        $display("  of them %0d occupied and %0d closing a frame, %0d mismatches", occupied_tiles,
                 frames_closed, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
